@@ src/rect_atlas_packer_assert.svh @@
// Assertion macros for the atlas packer.
`ifndef RECT_ATLAS_PACKER_ASSERT_SVH
`define RECT_ATLAS_PACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define RAP_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("atlas packer check failed");
`define RAP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("atlas packer check failed");
`else
`define RAP_ASSERT(lbl, cond)
`define RAP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ src/rap_pkg.sv @@
package rap_pkg;

  localparam int COORD_BITS = 14;

  // common width for coordinate sums and compares
  localparam int WIDE = 17;

  localparam logic [26:0] AREA_LIMIT = 27'd67108864;

  localparam logic [2:0] ADDR_ATLAS_W = 3'd0;
  localparam logic [2:0] ADDR_ATLAS_H = 3'd4;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_DROPPED = 2'd2,
    ST_RESTART = 2'd3
  } status_t;

endpackage

@@ src/rect_atlas_packer.sv @@
// Free-rectangle atlas packer. The free list lives in one synchronous RAM
// (one write, one registered read port) and every list step is a read
// followed by a use of the registered read data in the next state. A
// placement runs a best-fit scan over the entries, appends the remainder
// pieces, removes the chosen entry by moving the tail down, and then runs
// the containment prune over entry pairs; the single RAM port paces each
// step. One item is in work at a time; a finished result waits in the
// output register while the next item is accepted.
`include "rect_atlas_packer_assert.svh"
module rect_atlas_packer import rap_pkg::*; #(
  parameter int MAX_FREE   = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [13:0] rect_width,
  input  logic [13:0] rect_height,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [12:0] place_x,
  output logic [12:0] place_y,
  output logic [26:0] used_area
);

  localparam int CB   = COORD_BITS;
  localparam int IW   = $clog2(MAX_FREE);
  localparam int CNTW = $clog2(MAX_FREE + 1);
  localparam logic [WIDE-1:0] ATLAS_LIM = WIDE'(1) << (COORD_BITS - 1);

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] w;
    logic [CB-1:0] h;
  } frect_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_EV, S_GET_C, S_GET_CW, S_APP1, S_APP2,
    S_RM_CHK, S_RM_WR, S_P_I, S_P_IW, S_P_J, S_P_JW, S_FIN, S_DONE
  } state_t;

  state_t          state;
  state_t          ret;
  logic [13:0]     atlas_width;
  logic [13:0]     atlas_height;
  logic [13:0]     rw;
  logic [13:0]     rh;
  logic [27:0]     area_prod;
  logic [26:0]     area_total;
  logic [CNTW-1:0] count;
  logic [CNTW-1:0] k;
  logic [CNTW-1:0] i;
  logic [CNTW-1:0] j;
  logic [CNTW-1:0] rm_k;
  logic [CNTW-1:0] best;
  logic            found;
  logic [WIDE-1:0] best_s;
  logic [WIDE-1:0] best_l;
  frect_t          c;
  frect_t          ei;
  logic            ok;
  status_t         res_status;
  logic [12:0]     res_x;
  logic [12:0]     res_y;

  frect_t          mem [MAX_FREE];
  frect_t          rd_data;
  logic [IW-1:0]   rd_addr;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  frect_t          mem_wdata;

  logic            cfg_wr;
  logic            fits;
  logic            better;
  logic [WIDE-1:0] lx;
  logic [WIDE-1:0] ly;
  logic [WIDE-1:0] s_val;
  logic [WIDE-1:0] l_val;
  logic            room;
  frect_t          full_atlas;
  logic [28:0]     area_room;

  function automatic logic inside_of(frect_t a, frect_t b);
    return WIDE'(a.x) >= WIDE'(b.x) && WIDE'(a.y) >= WIDE'(b.y) &&
           WIDE'(a.x) + WIDE'(a.w) <= WIDE'(b.x) + WIDE'(b.w) &&
           WIDE'(a.y) + WIDE'(a.h) <= WIDE'(b.y) + WIDE'(b.h);
  endfunction

  function automatic logic [CB-1:0] clamp_dim(logic [13:0] v);
    return (WIDE'(v) > ATLAS_LIM) ? CB'(ATLAS_LIM) : CB'(WIDE'(v));
  endfunction

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_ready = (state == S_IDLE);
  assign room     = count < CNTW'(MAX_FREE);

  always_comb begin
    priority if (paddr == ADDR_ATLAS_W) prdata = {18'd0, atlas_width};
    else if (paddr == ADDR_ATLAS_H)     prdata = {18'd0, atlas_height};
    else                                prdata = 32'd0;
  end

  always_comb begin
    full_atlas.x = '0;
    full_atlas.y = '0;
    full_atlas.w = clamp_dim(atlas_width);
    full_atlas.h = clamp_dim(atlas_height);
  end

  // fit score of the entry just read
  always_comb begin
    fits  = WIDE'(rd_data.w) >= WIDE'(rw) && WIDE'(rd_data.h) >= WIDE'(rh);
    lx    = WIDE'(rd_data.w) - WIDE'(rw);
    ly    = WIDE'(rd_data.h) - WIDE'(rh);
    s_val = (lx < ly) ? lx : ly;
    l_val = (lx < ly) ? ly : lx;
    better = fits && (!found || s_val < best_s || (s_val == best_s && l_val < best_l));
  end

  assign area_room = 29'(AREA_LIMIT) - 29'(area_total);

  always_comb begin
    rd_addr   = k[IW-1:0];
    mem_we    = 1'b0;
    mem_waddr = count[IW-1:0];
    mem_wdata = full_atlas;
    unique case (state)
      S_IDLE: begin
        mem_we    = in_valid && req_type;
        mem_waddr = '0;
      end
      S_GET_C: rd_addr = best[IW-1:0];
      S_APP1: begin
        mem_we      = (WIDE'(rw) < WIDE'(c.w)) && room;
        mem_wdata.x = CB'(WIDE'(c.x) + WIDE'(rw));
        mem_wdata.y = c.y;
        mem_wdata.w = CB'(WIDE'(c.w) - WIDE'(rw));
        mem_wdata.h = c.h;
      end
      S_APP2: begin
        mem_we      = (WIDE'(rh) < WIDE'(c.h)) && room;
        mem_wdata.x = c.x;
        mem_wdata.y = CB'(WIDE'(c.y) + WIDE'(rh));
        mem_wdata.w = c.w;
        mem_wdata.h = CB'(WIDE'(c.h) - WIDE'(rh));
      end
      S_RM_CHK: rd_addr = IW'(rm_k + CNTW'(1));
      S_RM_WR: begin
        mem_we    = 1'b1;
        mem_waddr = rm_k[IW-1:0];
        mem_wdata = rd_data;
      end
      S_P_I: rd_addr = i[IW-1:0];
      S_P_J: rd_addr = j[IW-1:0];
      default: ;
    endcase
    // reset loads entry zero with the default full atlas
    if (rst) begin
      mem_we      = 1'b1;
      mem_waddr   = '0;
      mem_wdata   = '0;
      mem_wdata.w = clamp_dim(14'd2048);
      mem_wdata.h = clamp_dim(14'd2048);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ret          <= S_P_I;
      atlas_width  <= 14'd2048;
      atlas_height <= 14'd2048;
      count        <= CNTW'(1);
      area_total   <= '0;
      out_valid    <= 1'b0;
      found        <= 1'b0;
    end else begin
      if (cfg_wr && paddr == ADDR_ATLAS_W) atlas_width <= pwdata[13:0];
      if (cfg_wr && paddr == ADDR_ATLAS_H) atlas_height <= pwdata[13:0];
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rw        <= rect_width;
            rh        <= rect_height;
            area_prod <= rect_width * rect_height;
            k         <= '0;
            found     <= 1'b0;
            res_x     <= '0;
            res_y     <= '0;
            if (req_type) begin
              count      <= CNTW'(1);
              area_total <= '0;
              res_status <= ST_RESTART;
              state      <= S_DONE;
            end else begin
              state <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          if (k == count) begin
            if (found) begin
              state <= S_GET_C;
            end else begin
              res_status <= ST_NO_FIT;
              state      <= S_DONE;
            end
          end else begin
            state <= S_SCAN_EV;
          end
        end
        S_SCAN_EV: begin
          if (better) begin
            found  <= 1'b1;
            best   <= k;
            best_s <= s_val;
            best_l <= l_val;
          end
          k     <= k + CNTW'(1);
          state <= S_SCAN_RD;
        end
        S_GET_C: state <= S_GET_CW;
        S_GET_CW: begin
          c     <= rd_data;
          res_x <= 13'(WIDE'(rd_data.x));
          res_y <= 13'(WIDE'(rd_data.y));
          ok    <= 1'b1;
          state <= S_APP1;
        end
        S_APP1: begin
          if (WIDE'(rw) < WIDE'(c.w)) begin
            if (room) count <= count + CNTW'(1);
            else ok <= 1'b0;
          end
          state <= S_APP2;
        end
        S_APP2: begin
          if (WIDE'(rh) < WIDE'(c.h)) begin
            if (room) count <= count + CNTW'(1);
            else ok <= 1'b0;
          end
          rm_k  <= best;
          ret   <= S_P_I;
          i     <= '0;
          state <= S_RM_CHK;
        end
        // remove entry rm_k by moving the tail down one place
        S_RM_CHK: begin
          if (rm_k + CNTW'(1) >= count) begin
            count <= count - CNTW'(1);
            state <= ret;
          end else begin
            state <= S_RM_WR;
          end
        end
        S_RM_WR: begin
          rm_k  <= rm_k + CNTW'(1);
          state <= S_RM_CHK;
        end
        S_P_I: begin
          if (i >= count) state <= S_FIN;
          else            state <= S_P_IW;
        end
        S_P_IW: begin
          ei    <= rd_data;
          j     <= i + CNTW'(1);
          state <= S_P_J;
        end
        S_P_J: begin
          if (j >= count) begin
            i     <= i + CNTW'(1);
            state <= S_P_I;
          end else begin
            state <= S_P_JW;
          end
        end
        S_P_JW: begin
          priority if (inside_of(ei, rd_data)) begin
            rm_k  <= i;
            ret   <= S_P_I;
            state <= S_RM_CHK;
          end else if (inside_of(rd_data, ei)) begin
            rm_k  <= j;
            ret   <= S_P_J;
            state <= S_RM_CHK;
          end else begin
            j     <= j + CNTW'(1);
            state <= S_P_J;
          end
        end
        S_FIN: begin
          if ({1'b0, area_prod} >= area_room) area_total <= AREA_LIMIT;
          else area_total <= area_total + 27'(area_prod);
          res_status <= ok ? ST_PLACED : ST_DROPPED;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= res_status;
            place_x   <= res_x;
            place_y   <= res_y;
            used_area <= area_total;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RAP_ASSERT(a_count_max, count <= CNTW'(MAX_FREE))
  `RAP_ASSERT_NEXT(a_restart_count, in_valid && in_ready && req_type, count == CNTW'(1))
  `RAP_ASSERT(a_best_valid, state != S_GET_C || best < count)

endmodule

@@ dv/tb_top.sv @@
`default_nettype none
module tb_top import rap_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFREE = 64;
  localparam int unsigned ATLAS_CAP = 8192;
  localparam int unsigned AREA_CAP = 67108864;
  localparam int STALL_LIMIT = 100000;

  typedef struct {
    status_t     st;
    logic [12:0] x;
    logic [12:0] y;
    logic [26:0] area;
  } placement_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic [13:0] rect_width = '0, rect_height = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [12:0] place_x, place_y;
  logic [26:0] used_area;

  rect_atlas_packer u_top (.*);

  always #1 clk = ~clk;

  // packer shadow state
  int unsigned fx[NFREE], fy[NFREE], fw[NFREE], fh[NFREE];
  int unsigned free_n;
  int unsigned placed_area;
  int unsigned atlas_w = 2048, atlas_h = 2048;

  placement_t placement_q[$];
  int errors = 0;
  int items_sent = 0, n_restart = 0, n_nofit = 0, n_dropped = 0;
  int burst_left = 0;
  int hold_cycles = 0;

  function automatic void restart_atlas();
    for (int k = 0; k < NFREE; k++) begin
      fx[k] = 0; fy[k] = 0; fw[k] = 0; fh[k] = 0;
    end
    fw[0] = (atlas_w > ATLAS_CAP) ? ATLAS_CAP : atlas_w;
    fh[0] = (atlas_h > ATLAS_CAP) ? ATLAS_CAP : atlas_h;
    free_n = 1;
    placed_area = 0;
  endfunction

  function automatic bit covered_by(int a, int b);
    return fx[a] >= fx[b] && fy[a] >= fy[b] &&
           fx[a] + fw[a] <= fx[b] + fw[b] && fy[a] + fh[a] <= fy[b] + fh[b];
  endfunction

  function automatic void drop_entry(int k);
    if (k >= free_n) return;
    for (int m = k; m < free_n - 1; m++) begin
      fx[m] = fx[m+1]; fy[m] = fy[m+1]; fw[m] = fw[m+1]; fh[m] = fh[m+1];
    end
    free_n--;
    fx[free_n] = 0; fy[free_n] = 0; fw[free_n] = 0; fh[free_n] = 0;
  endfunction

  function automatic bit add_entry(int unsigned x, int unsigned y, int unsigned w,
                                   int unsigned h);
    if (free_n >= NFREE) return 1'b0;
    fx[free_n] = x & 14'h3fff; fy[free_n] = y & 14'h3fff;
    fw[free_n] = w & 14'h3fff; fh[free_n] = h & 14'h3fff;
    free_n++;
    return 1'b1;
  endfunction

  function automatic void prune_contained();
    int i;
    int j;
    bit gone;
    i = 0;
    while (i < free_n) begin
      gone = 1'b0;
      j = i + 1;
      while (j < free_n) begin
        if (covered_by(i, j)) begin
          drop_entry(i);
          gone = 1'b1;
          break;
        end else if (covered_by(j, i)) drop_entry(j);
        else j++;
      end
      if (!gone) i++;
    end
  endfunction

  function automatic placement_t place_rect(bit rq, int unsigned rw, int unsigned rh);
    placement_t r;
    int best;
    int unsigned bs, bl, lx, ly, s, l, cx, cy, cw, ch, a;
    bit ok;
    r.x = '0; r.y = '0;
    if (rq) begin
      restart_atlas();
      r.st = ST_RESTART;
    end else begin
      best = -1; bs = '1; bl = '1;
      for (int k = 0; k < free_n; k++) begin
        if (fw[k] >= rw && fh[k] >= rh) begin
          lx = fw[k] - rw; ly = fh[k] - rh;
          s = (lx < ly) ? lx : ly;
          l = (lx < ly) ? ly : lx;
          if (s < bs || (s == bs && l < bl)) begin
            best = k; bs = s; bl = l;
          end
        end
      end
      if (best < 0) r.st = ST_NO_FIT;
      else begin
        cx = fx[best]; cy = fy[best]; cw = fw[best]; ch = fh[best];
        ok = 1'b1;
        r.x = cx[12:0]; r.y = cy[12:0];
        if (rw < cw) ok = add_entry(cx + rw, cy, cw - rw, ch) && ok;
        if (rh < ch) ok = add_entry(cx, cy + rh, cw, ch - rh) && ok;
        drop_entry(best);
        prune_contained();
        a = rw * rh;
        if (a >= AREA_CAP - placed_area) placed_area = AREA_CAP;
        else placed_area += a;
        r.st = ok ? ST_PLACED : ST_DROPPED;
      end
    end
    r.area = placed_area[26:0];
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    placement_t e;
    if (!rst && out_valid && out_ready) begin
      if (placement_q.size() == 0) begin
        $error("unexpected result status=%0d", status);
        errors++;
      end else begin
        e = placement_q.pop_front();
        if (status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, status); errors++;
        end
        if (place_x !== e.x) begin
          $error("place_x: expected %0d, got %0d", e.x, place_x); errors++;
        end
        if (place_y !== e.y) begin
          $error("place_y: expected %0d, got %0d", e.y, place_y); errors++;
        end
        if (used_area !== e.area) begin
          $error("used_area: expected %0d, got %0d", e.area, used_area); errors++;
        end
      end
    end
  end

  // receiver: random stall pattern picked from three modes, plus long hold-offs
  always @(negedge clk) begin
    int mode;
    int phase;
    if (phase == 0) mode = $urandom_range(0, 2);
    phase = (phase + 1) % 64;
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else case (mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    int idle;
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
    else idle++;
    if (idle >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(bit rq, int unsigned w, int unsigned h);
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end else @(negedge clk);
    in_valid = 1'b1;
    req_type = rq;
    rect_width = w[13:0];
    rect_height = h[13:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    placement_q = {placement_q, place_rect(rq, 32'(rect_width), 32'(rect_height))};
    items_sent++;
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, int unsigned val);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (addr == ADDR_ATLAS_W) atlas_w = val & 14'h3fff;
    else atlas_h = val & 14'h3fff;
  endtask

  task automatic set_atlas(int unsigned w, int unsigned h);
    drain();
    write_reg(ADDR_ATLAS_W, w);
    write_reg(ADDR_ATLAS_H, h);
  endtask

  function automatic int unsigned pick_dim(int unsigned lim);
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 8192);
      1, 2: return $urandom_range(0, (lim > 0) ? lim : 1);
      default: return $urandom_range(1, (lim / 8 > 1) ? lim / 8 : 1);
    endcase
  endfunction

  task automatic test_directed();
    send_item(1'b0, 0, 0);         // zero size fits anything
    send_item(1'b0, 2049, 1);      // too wide
    send_item(1'b0, 100, 50);
    send_item(1'b0, 8192, 8192);
    send_item(1'b0, 1948, 2048);
    send_item(1'b1, 16383, 16383); // restart, sizes ignored
    send_item(1'b0, 2048, 2048);   // exact fill
    send_item(1'b0, 1, 1);
    send_item(1'b1, 0, 0);
    set_atlas(8192, 8192);
    send_item(1'b1, 0, 0);
    send_item(1'b0, 8192, 8192);   // area reaches the cap
    send_item(1'b0, 0, 0);
    send_item(1'b1, 0, 0);
    send_item(1'b0, 4096, 8192);
    send_item(1'b0, 4096, 8192);
    send_item(1'b0, 0, 0);         // saturated already
    set_atlas(16383, 16383);       // clamps on restart
    send_item(1'b1, 0, 0);
    send_item(1'b0, 8192, 1);
    set_atlas(0, 0);               // zero-size atlas
    send_item(1'b1, 0, 0);
    send_item(1'b0, 0, 0);
    send_item(1'b0, 1, 0);
    set_atlas(1, 1);
    send_item(1'b1, 0, 0);
    send_item(1'b0, 1, 1);
  endtask

  // many small pieces push the free list toward full
  task automatic test_fill();
    set_atlas(8192, 8192);
    send_item(1'b1, 0, 0);
    for (int n = 0; n < 70; n++)
      send_item(1'b0, $urandom_range(1, 600), $urandom_range(1, 600));
  endtask

  task automatic test_random(int count);
    int unsigned lim;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: set_atlas(2048, 2048);
          1: set_atlas($urandom_range(1, 8192), $urandom_range(1, 8192));
          2: set_atlas($urandom_range(1, 256), $urandom_range(1, 256));
          default: set_atlas(8192, $urandom_range(1, 16383));
        endcase
        send_item(1'b1, $urandom_range(0, 16383), $urandom_range(0, 16383));
      end
      lim = (atlas_w < atlas_h) ? atlas_w : atlas_h;
      if (lim > ATLAS_CAP) lim = ATLAS_CAP;
      if ($urandom_range(0, 19) == 0) send_item(1'b1, pick_dim(8192), pick_dim(8192));
      else send_item(1'b0, pick_dim(lim), pick_dim(lim));
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_cycles = 3000;
    for (int n = 0; n < 20; n++) send_item(1'b0, $urandom_range(0, 300), $urandom_range(0, 300));
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      if (req_type) n_restart++;
    end
    if (!rst && out_valid && out_ready) begin
      if (status == ST_NO_FIT) n_nofit++;
      if (status == ST_DROPPED) n_dropped++;
    end
  end

  initial begin
    restart_atlas();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_fill();
    test_random(148);
    test_backpressure();
    drain();
    $display("Sent %0d items: %0d restarts, %0d without space, %0d with dropped remainder",
             items_sent, n_restart, n_nofit, n_dropped);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

@@ rect_atlas_packer.f @@
+incdir+src
src/rap_pkg.sv
src/rect_atlas_packer.sv
dv/tb_top.sv
